/* hdl/iwc_pkg.sv */
// Shared types and register codes for the image window crop block.
package iwc_pkg;

   // Configuration register indexes
   localparam logic [2:0] CsrSrcWidth  = 3'd0;
   localparam logic [2:0] CsrSrcHeight = 3'd1;
   localparam logic [2:0] CsrPixDepth  = 3'd2;
   localparam logic [2:0] CsrWinLeft   = 3'd3;
   localparam logic [2:0] CsrWinRight  = 3'd4;
   localparam logic [2:0] CsrWinBottom = 3'd5;
   localparam logic [2:0] CsrWinTop    = 3'd6;

   // Queue between classifier and output sequencer
   localparam int QueueDepth = 4;
   localparam int QueueAw    = 2;

   // Decoded window geometry, byte positions within a source row
   typedef struct packed {
      logic        ok;      // geometry settled since the last write
      logic        empty;   // clamped window holds nothing
      logic [14:0] lo;      // first kept byte of a row
      logic [14:0] hi;      // last kept byte of a row
      logic [14:0] len;     // source row length with padding
      logic [12:0] b;       // first kept row
      logic [12:0] t;       // last kept row
      logic [12:0] h;       // clamped source height
      logic [1:0]  tp;      // padding bytes after each cropped row
   } geom_type;

   // One kept byte and what follows it
   typedef struct packed {
      logic [7:0] data;
      logic       last;     // last kept byte of the row
      logic [1:0] tp;       // padding bytes to add after it
      logic       ie;       // last kept byte of the last kept row
   } entry_type;

   function automatic logic [1:0] row_pad(input logic depth, input logic [1:0] w);
      row_pad = depth ? w : (w[0] ? 2'd2 : 2'd0);
   endfunction

endpackage

/* hdl/iwc_cfg.sv */
// Configuration registers and window geometry decode.
module iwc_cfg import iwc_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata,
   output geom_type    geom
);

   localparam logic [12:0] WMax = 13'((MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH);
   localparam logic [12:0] HMax = 13'((MAX_HEIGHT > 8191) ? 8191 : MAX_HEIGHT);

   logic [12:0] src_width_ff, src_height_ff;
   logic        pix_depth_ff;
   logic [12:0] win_left_ff, win_right_ff, win_bottom_ff, win_top_ff;

   // first stage: clamped bounds
   logic [12:0] w_in, h_in, w_ff, h_ff;
   logic signed [13:0] l_in, r_in, b_in, t_in, l_ff, r_ff, b_ff, t_ff;
   logic signed [13:0] rlim, tlim;
   logic        depth_ff;

   // second stage
   geom_type    geom_in, geom_ff;
   logic [1:0]  settle_ff, settle_in;
   logic [14:0] w3, rp3;
   logic [12:0] rp1;
   logic [1:0]  cw;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 13'd1;
         src_height_ff <= 13'd1;
         pix_depth_ff  <= 1'b1;
         win_left_ff   <= 13'd0;
         win_right_ff  <= 13'd4095;
         win_bottom_ff <= 13'd0;
         win_top_ff    <= 13'd4095;
      end else if (csr_we) begin
         case (csr_index)
            CsrSrcWidth:  src_width_ff  <= csr_wdata;
            CsrSrcHeight: src_height_ff <= csr_wdata;
            CsrPixDepth:  pix_depth_ff  <= csr_wdata[0];
            CsrWinLeft:   win_left_ff   <= csr_wdata;
            CsrWinRight:  win_right_ff  <= csr_wdata;
            CsrWinBottom: win_bottom_ff <= csr_wdata;
            CsrWinTop:    win_top_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      w_in = (src_width_ff == 13'd0) ? 13'd1 : ((src_width_ff > WMax) ? WMax : src_width_ff);
      h_in = (src_height_ff == 13'd0) ? 13'd1 : ((src_height_ff > HMax) ? HMax : src_height_ff);
      rlim = $signed({1'b0, w_in}) - 14'sd1;
      tlim = $signed({1'b0, h_in}) - 14'sd1;
      l_in = win_left_ff[12] ? 14'sd0 : $signed({1'b0, win_left_ff});
      b_in = win_bottom_ff[12] ? 14'sd0 : $signed({1'b0, win_bottom_ff});
      r_in = ($signed({win_right_ff[12], win_right_ff}) > rlim) ? rlim
           : $signed({win_right_ff[12], win_right_ff});
      t_in = ($signed({win_top_ff[12], win_top_ff}) > tlim) ? tlim
           : $signed({win_top_ff[12], win_top_ff});
   end

   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      h_ff     <= h_in;
      l_ff     <= l_in;
      r_ff     <= r_in;
      b_ff     <= b_in;
      t_ff     <= t_in;
      depth_ff <= pix_depth_ff;
   end

   always_comb begin
      w3  = 15'({w_ff, 1'b0}) + (depth_ff ? 15'(w_ff) : 15'd0);
      rp1 = r_ff[12:0] + 13'd1;
      rp3 = 15'({rp1, 1'b0}) + (depth_ff ? 15'(rp1) : 15'd0);
      cw  = r_ff[1:0] - l_ff[1:0] + 2'd1;

      settle_in = (settle_ff == 2'd3) ? 2'd3 : settle_ff + 2'd1;
      if (csr_we) settle_in = 2'd0;

      geom_in.ok    = (settle_ff == 2'd3) && !csr_we;
      geom_in.empty = (l_ff > r_ff) || (b_ff > t_ff);
      geom_in.lo    = 15'({l_ff[12:0], 1'b0}) + (depth_ff ? 15'(l_ff[12:0]) : 15'd0);
      geom_in.hi    = rp3 - 15'd1;
      geom_in.len   = w3 + 15'(row_pad(depth_ff, w_ff[1:0]));
      geom_in.b     = b_ff[12:0];
      geom_in.t     = t_ff[12:0];
      geom_in.h     = h_ff;
      geom_in.tp    = row_pad(depth_ff, cw);
   end

   // hold off until both decode stages reflect the current registers
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= 2'd0;
      end else begin
         settle_ff <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff <= '0;
      end else begin
         geom_ff <= geom_in;
      end
   end

   assign geom = geom_ff;

endmodule

/* hdl/iwc_front.sv */
// Input side: row and byte counters, window test and queue push.
module iwc_front import iwc_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  geom_type   geom,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       q_full,
   output logic       q_push,
   output entry_type  q_wdata
);

   localparam int WMax = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
   localparam int HMax = (MAX_HEIGHT > 8191) ? 8191 : MAX_HEIGHT;
   localparam int RowW  = $clog2(HMax);
   localparam int ByteW = $clog2(3 * WMax + 3);

   logic [RowW-1:0]  row_ff, row_in;
   logic [ByteW-1:0] pos_ff, pos_in;
   logic [15:0]      pos16, row16;
   logic             accept, in_win, last;

   assign req_tready = geom.ok && !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      pos16  = 16'(pos_ff);
      row16  = 16'(row_ff);
      in_win = !geom.empty
            && row16 >= 16'(geom.b) && row16 <= 16'(geom.t)
            && pos16 >= 16'(geom.lo) && pos16 <= 16'(geom.hi);
      last   = pos16 == 16'(geom.hi);

      q_push       = accept && in_win;
      q_wdata.data = req_tdata;
      q_wdata.last = last;
      q_wdata.tp   = last ? geom.tp : 2'd0;
      q_wdata.ie   = last && row16 == 16'(geom.t);

      // end a row at or past its length; wrap rows at or past the height
      row_in = row_ff;
      pos_in = pos_ff;
      if (accept) begin
         if (pos16 + 16'd1 >= 16'(geom.len)) begin
            pos_in = '0;
            row_in = (row16 + 16'd1 >= 16'(geom.h)) ? '0 : row_ff + 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         pos_ff <= '0;
      end else begin
         row_ff <= row_in;
         pos_ff <= pos_in;
      end
   end

endmodule

/* hdl/iwc_fifo.sv */
// Short queue of kept bytes between the classifier and the sequencer.
module iwc_fifo import iwc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type wdata,
   input  logic      pop,
   output entry_type rdata,
   output logic      full,
   output logic      empty
);

   localparam int CntW = $clog2(QueueDepth + 1);

   entry_type          mem_ff [QueueDepth];
   logic [QueueAw-1:0] wr_ff, rd_ff;
   logic [CntW-1:0]    cnt_ff;

   assign full  = cnt_ff == CntW'(QueueDepth);
   assign empty = cnt_ff == '0;
   assign rdata = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

/* hdl/iwc_back.sv */
// Output side: emit each kept byte, then its row padding, through an output register.
module iwc_back import iwc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  q_rdata,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic [1:0] rsp_tuser
);

   logic       valid_ff, valid_in;
   logic [1:0] pad_left_ff, pad_left_in;
   logic       ie_hold_ff, ie_hold_in;
   logic [7:0] byte_ff, byte_in;
   logic       pad_ff, pad_in, last_ff, last_in, end_ff, end_in;
   logic       load;

   assign load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in    = valid_ff;
      pad_left_in = pad_left_ff;
      ie_hold_in  = ie_hold_ff;
      byte_in     = byte_ff;
      pad_in      = pad_ff;
      last_in     = last_ff;
      end_in      = end_ff;
      q_pop       = 1'b0;
      if (load) begin
         if (pad_left_ff != 2'd0) begin
            valid_in    = 1'b1;
            byte_in     = 8'd0;
            pad_in      = 1'b1;
            last_in     = pad_left_ff == 2'd1;
            end_in      = (pad_left_ff == 2'd1) && ie_hold_ff;
            pad_left_in = pad_left_ff - 2'd1;
         end else if (!q_empty) begin
            q_pop       = 1'b1;
            valid_in    = 1'b1;
            byte_in     = q_rdata.data;
            pad_in      = 1'b0;
            last_in     = q_rdata.last && q_rdata.tp == 2'd0;
            end_in      = q_rdata.ie && q_rdata.tp == 2'd0;
            pad_left_in = q_rdata.tp;
            ie_hold_in  = q_rdata.ie;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         pad_left_ff <= 2'd0;
         ie_hold_ff  <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         pad_left_ff <= pad_left_in;
         ie_hold_ff  <= ie_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      pad_ff  <= pad_in;
      last_ff <= last_in;
      end_ff  <= end_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {end_ff, pad_ff};

endmodule

/* hdl/image_window_crop.sv */
// Top level of the bitmap window crop: row-padded byte stream in, cropped stream out.
//
// Takes the pixel-data bytes of a bitmap one transfer per cycle, in stored row order with
// source row padding included, and passes on only the bytes inside the window after the
// window is clamped to the image. Each cropped row is followed by zero bytes that pad it
// to a multiple of four (width mod 4 at 24 bpp, two bytes for an odd width at 16 bpp).
// Input and output each move one byte per cycle unless stalled. The last kept byte of a
// row turns into up to four output transfers; the source bytes dropped between two
// cropped rows (source padding and columns outside the window) always cover the added
// padding, so with the receiver ready the input never stalls. A kept byte leaves through
// the queue and the output register. A four-entry queue between the classifier and the
// output sequencer lets each side stall on its own; the input stalls only when the
// receiver holds off and the queue fills. Geometry is decoded in two register stages;
// after reset and each register write, req_tready stays low until both are current.
// Registers must be written only while idle; the block itself does not enforce this.
module image_window_crop import iwc_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // source bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   // cropped bytes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // row_end
   output logic [1:0]  rsp_tuser,   // [0] is_pad, [1] image_end
   // configuration writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   geom_type  geom;
   entry_type q_wdata, q_rdata;
   logic      q_push, q_pop, q_full, q_empty;

   // registers and geometry decode
   iwc_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   // count positions, drop bytes outside the window
   iwc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   iwc_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   // emit kept bytes and append the new row padding
   iwc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_rdata    (q_rdata),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // an inserted padding byte is always zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 8'd0)
      else $error("padding byte not zero");

   // the end of the image also ends a row
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("image end without row end");

   // a full queue must back-pressure the source
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_tready)
      else $error("source accepted into a full queue");

endmodule

/* tb/tb_image_window_crop.sv */
// Self-checking testbench for the bitmap window crop: random stream traffic against a predictor.
`timescale 1ns / 1ps

module tb_image_window_crop;
   import iwc_pkg::*;

   localparam int MaxW         = 4096;
   localparam int MaxH         = 4096;
   localparam int IdlePct      = 31;    // idle cycles per hundred on either side
   localparam int HoldCycles   = 120;   // long receiver hold-off, enough to fill the block
   localparam int DrainCycles  = 12;    // geometry stages, queue and output register
   localparam int RandomItems  = 210;

   // One cropped byte as it should leave the block
   typedef struct {
      logic [7:0] data;
      logic       pad;
      logic       row_end;
      logic       img_end;
   } crop_byte_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CsrSrcWidth;
   logic [12:0] csr_wdata = 13'd0;

   // Mirror of the geometry registers, reset values
   logic [12:0]        geo_width  = 13'd1;
   logic [12:0]        geo_height = 13'd1;
   logic               geo_depth  = 1'b1;
   logic signed [12:0] win_l = 13'sd0;
   logic signed [12:0] win_r = 13'sd4095;
   logic signed [12:0] win_b = 13'sd0;
   logic signed [12:0] win_t = 13'sd4095;

   // Position of the next source byte within the stored image
   int row_at = 0;
   int col_at = 0;

   logic [7:0] src_bytes[$];     // source bytes waiting to be offered
   crop_byte_t crop_due[$];      // cropped bytes predicted but not yet seen
   int src_given   = 0;
   int src_taken   = 0;
   int rsp_seen    = 0;
   int errors      = 0;
   int hold_asked  = 0;
   int hold_served = 0;
   int hold_left   = 0;

   image_window_crop #(
      .MAX_WIDTH (MaxW),
      .MAX_HEIGHT(MaxH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Geometry helpers
   // ------------------------------------------------------------------

   function automatic int clamp_dim(input int v, input int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // Padding bytes that follow a row of w pixels at the current depth
   function automatic int line_pad(input int w);
      return geo_depth ? w % 4 : ((w % 2 != 0) ? 2 : 0);
   endfunction

   // Stored length of one source row, padding included
   function automatic int row_bytes();
      int w;
      w = clamp_dim(int'(geo_width), MaxW);
      return w * (geo_depth ? 3 : 2) + line_pad(w);
   endfunction

   // Work out what one accepted source byte produces, then advance the position
   task automatic crop_advance(input logic [7:0] b);
      int bpp, w, h, l, r, bt, t, lo, hi, tp, k;
      logic last, ie;
      bpp = geo_depth ? 3 : 2;
      w   = clamp_dim(int'(geo_width), MaxW);
      h   = clamp_dim(int'(geo_height), MaxH);
      l   = (win_l < 0) ? 0 : int'(win_l);
      r   = (int'(win_r) > w - 1) ? w - 1 : int'(win_r);
      bt  = (win_b < 0) ? 0 : int'(win_b);
      t   = (int'(win_t) > h - 1) ? h - 1 : int'(win_t);
      if (l <= r && bt <= t && row_at >= bt && row_at <= t) begin
         lo = l * bpp;
         hi = (r + 1) * bpp - 1;
         if (col_at >= lo && col_at <= hi) begin
            last = (col_at == hi);
            tp   = last ? line_pad(r - l + 1) : 0;
            ie   = last && (row_at == t);
            crop_due.push_back('{b, 1'b0, last && (tp == 0), ie && (tp == 0)});
            for (k = 0; k < tp; k++) begin
               crop_due.push_back('{8'h00, 1'b1, k == tp - 1, ie && (k == tp - 1)});
            end
         end
      end
      // A position at or past the row length (after a mid-image write) ends the row
      if (col_at + 1 >= row_bytes()) begin
         col_at = 0;
         row_at = (row_at + 1 >= h) ? 0 : row_at + 1;
      end else begin
         col_at++;
      end
   endtask

   task automatic report_fault(input string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   // ------------------------------------------------------------------
   // Register writes: one per rising edge, only while the block is idle
   // ------------------------------------------------------------------

   task automatic csr_put(input logic [2:0] idx, input int val);
      logic [12:0] v;
      v = val[12:0];
      case (idx)
         CsrSrcWidth:  geo_width  = v;
         CsrSrcHeight: geo_height = v;
         CsrPixDepth:  geo_depth  = v[0];
         CsrWinLeft:   win_l      = v;
         CsrWinRight:  win_r      = v;
         CsrWinBottom: win_b      = v;
         CsrWinTop:    win_t      = v;
         default: ;
      endcase
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
   endtask

   task automatic set_geometry(input int w, input int h, input logic d,
                               input int l, input int r, input int bt, input int t);
      csr_put(CsrSrcWidth, w);
      csr_put(CsrSrcHeight, h);
      csr_put(CsrPixDepth, int'(d));
      csr_put(CsrWinLeft, l);
      csr_put(CsrWinRight, r);
      csr_put(CsrWinBottom, bt);
      csr_put(CsrWinTop, t);
      csr_we <= 1'b0;
   endtask

   task automatic push_byte(input logic [7:0] b);
      src_bytes.push_back(b);
      src_given++;
   endtask

   task automatic push_random(input int n);
      repeat (n) push_byte(8'($urandom_range(255)));
   endtask

   // Hold the sender until every byte is taken and every predicted result has come,
   // then let the pipeline settle for the given number of cycles
   task automatic wait_drained(input int settle);
      do @(posedge clock); while (src_taken != src_given || crop_due.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Source driver: offer queued bytes, predict each accepted transfer
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
      end else begin
         if (req_tvalid && req_tready) begin
            crop_advance(req_tdata);
            src_taken++;
         end
         // Only move on once the offered byte is gone; every fourth block of forty
         // transfers runs without gaps
         if (!req_tvalid || req_tready) begin
            if (src_bytes.size() != 0 &&
                (((src_taken / 40) % 4) == 3 || $urandom_range(99) >= IdlePct)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= src_bytes.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: compare each transfer with the oldest prediction,
   // and drive the receiver's ready with random stalls and long holds
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      crop_byte_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (crop_due.size() == 0) begin
               report_fault($sformatf("unexpected transfer: data %02h pad %b last %b end %b",
                                      rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]));
            end else begin
               want = crop_due.pop_front();
               if (rsp_tdata !== want.data || rsp_tuser[0] !== want.pad ||
                   rsp_tlast !== want.row_end || rsp_tuser[1] !== want.img_end) begin
                  report_fault($sformatf(
                     "transfer %0d: expected data %02h pad %b last %b end %b, got %02h %b %b %b",
                     rsp_seen, want.data, want.pad, want.row_end, want.img_end,
                     rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]));
               end
            end
            rsp_seen++;
         end
         if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HoldCycles;
            rsp_tready  <= 1'b0;
         end else begin
            rsp_tready <= ((rsp_seen / 40) % 4) == 3 || $urandom_range(99) >= IdlePct;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   initial begin
      int w, h, l, r, bt, t, n, len;
      logic d;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: one 24 bpp pixel plus one source pad byte, cropped to the same
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h5A);
      push_byte(8'hA5);
      wait_drained(DrainCycles);

      // 16 bpp, odd cropped width: two inserted pad bytes per row; far-left window clamps
      set_geometry(1, 2, 1'b0, -4096, 0, 0, 4095);
      push_random(8);
      wait_drained(DrainCycles);

      // Empty window by columns, then by rows: nothing comes out, counting goes on
      set_geometry(3, 2, 1'b1, 2, 1, 0, 1);
      push_random(2);
      wait_drained(DrainCycles);
      set_geometry(3, 2, 1'b1, 0, 2, 1, 0);
      push_random(2);
      wait_drained(DrainCycles);

      // Out-of-range geometry: width above the maximum, height of zero, extreme bounds
      set_geometry(8191, 0, 1'b1, -4096, 4095, -4096, 4095);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'h81);
      wait_drained(DrainCycles);

      // Change mid-image: the current position lies past the new row length, width zero
      set_geometry(0, 1, 1'b1, 0, 0, 0, 0);
      push_random(4);
      wait_drained(DrainCycles);

      // Full-window image with a long receiver hold-off, so the block fills and stalls
      // its input; then pause the sender until everything has come before the next image
      set_geometry(4, 2, 1'b1, 0, 3, 0, 1);
      hold_asked++;
      push_random(24);
      wait_drained(0);
      push_random(24);
      wait_drained(DrainCycles);

      while (src_given < RandomItems) begin
         d = 1'($urandom_range(1));
         if ($urandom_range(7) == 0) begin
            // Oversized or odd geometry: long rows, so only a short partial stream
            w  = $urandom_range(8191);
            h  = $urandom_range(8191);
            l  = int'($urandom_range(8191)) - 4096;
            r  = int'($urandom_range(8191)) - 4096;
            bt = int'($urandom_range(8191)) - 4096;
            t  = int'($urandom_range(8191)) - 4096;
            set_geometry(w, h, d, l, r, bt, t);
            push_random($urandom_range(4, 12));
         end else begin
            w  = $urandom_range(1, 7);
            h  = $urandom_range(1, 3);
            l  = int'($urandom_range(w + 2)) - 2;
            r  = int'($urandom_range(w + 2)) - 1;
            bt = int'($urandom_range(h + 1)) - 1;
            t  = int'($urandom_range(h + 2)) - 1;
            if ($urandom_range(7) == 0) l = -4096;
            if ($urandom_range(7) == 0) r = 4095;
            if ($urandom_range(7) == 0) bt = -4096;
            if ($urandom_range(7) == 0) t = 4095;
            set_geometry(w, h, d, l, r, bt, t);
            len = row_bytes();
            // Mostly whole images; now and then a partial one that leaves the next
            // geometry to start mid-image
            n = ($urandom_range(4) == 0) ? $urandom_range(1, len * h) : len * h;
            if (n > RandomItems - src_given) n = RandomItems - src_given;
            push_random(n);
         end
         wait_drained(DrainCycles);
      end

      wait_drained(DrainCycles);
      if (crop_due.size() != 0) report_fault("predicted results left over");
      if (errors == 0) begin
         $display("tb_image_window_crop: done, clean");
      end else begin
         $display("tb_image_window_crop: done, errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("tb_image_window_crop: done, errors");
      $finish;
   end

endmodule

/* image_window_crop.f */
hdl/iwc_pkg.sv
hdl/iwc_cfg.sv
hdl/iwc_front.sv
hdl/iwc_fifo.sv
hdl/iwc_back.sv
hdl/image_window_crop.sv
tb/tb_image_window_crop.sv
